>>> design/hta_pkg.sv
// ----------------------------------------------------------------------------
// hta_pkg
// Shared types and constants for the handle table allocator.
// ----------------------------------------------------------------------------
package hta_pkg;

    localparam int TABLE_SLOTS = 1024;

    // Used bits are kept as a bitmap of ROW_W-bit rows.
    localparam int ROW_W     = 32;
    localparam int BIT_W     = $clog2(ROW_W);
    localparam int ROWS      = (TABLE_SLOTS + ROW_W - 1) / ROW_W;
    localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    localparam int WORD_W       = 32;
    localparam int HANDLE_OUT_W = 13;

    typedef enum logic [1:0] {
        CMD_ALLOCATE = 2'd0,
        CMD_FREE     = 2'd1,
        CMD_LOOKUP   = 2'd2
    } t_command;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]        command;
        logic [WORD_W-1:0] object_id;
        logic [WORD_W-1:0] access_rights;
        logic [WORD_W-1:0] handle_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]              status;
        logic [HANDLE_OUT_W-1:0] handle_out;
        logic [WORD_W-1:0]       found_object;
        logic [WORD_W-1:0]       found_access;
    } t_out_item;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch the command, issue memory reads
        logic exec;     // finish the command, write back, load result
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free; // output register can take a result this cycle
    } t_dp_status;

endpackage

>>> design/hta_ctrl.sv
// ----------------------------------------------------------------------------
// hta_ctrl
// Sequencer: accept a command, then execute it once the output is free.
// ----------------------------------------------------------------------------
module hta_ctrl
    import hta_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                // no transfer is taken while reset is held
                o_in_stall = !i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            S_EXEC: begin
                o_cmd.exec = i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> design/hta_dpath.sv
// ----------------------------------------------------------------------------
// hta_dpath
// Slot storage, used-bit bitmap with row summary, handle decode and result
// register.
// ----------------------------------------------------------------------------
module hta_dpath
    import hta_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_cmd  i_cmd,
    input  t_in_item   i_in_item,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item
);

    // storage
    logic [ROW_W-1:0]      bitmap_mem [ROWS];
    logic [2*WORD_W-1:0]   slot_mem   [TABLE_SLOTS];
    logic [ROWS-1:0]       r_row_valid;
    logic [ROWS-1:0]       r_row_full;

    // latched command
    logic [1:0]            r_command;
    logic [WORD_W-1:0]     r_object;
    logic [WORD_W-1:0]     r_access;
    logic                  r_range_ok;
    logic                  r_full;
    logic [ROW_IDX_W-1:0]  r_row;
    logic [BIT_W-1:0]      r_hbit;
    logic [ROW_W-1:0]      r_bm_rd;
    logic                  r_bm_rd_valid;
    logic [2*WORD_W-1:0]   r_slot_rd;

    // output register
    logic                  r_out_valid;
    t_out_item             r_out_item;

    // accept-side decode
    logic [WORD_W-3:0]     hword;
    logic                  range_ok;
    logic [IDX_W-1:0]      h_idx;
    logic [ROW_IDX_W-1:0]  free_row;
    logic                  all_full;
    logic [ROW_IDX_W-1:0]  rd_row;

    // execute-side logic
    logic [ROW_W-1:0]      pad_mask;
    logic [ROW_W-1:0]      row_eff;
    logic [BIT_W-1:0]      free_bit;
    logic [IDX_W-1:0]      slot_idx;
    logic                  hit;
    logic                  bm_we;
    logic                  slot_we;
    logic [ROW_W-1:0]      new_row;
    t_out_item             result;

    // ---------------------------------------------------------------- decode
    assign hword    = i_in_item.handle_in[WORD_W-1:2];
    assign range_ok = (i_in_item.handle_in[1:0] == 2'b00) && (hword != '0)
                      && ({2'b00, hword} <= WORD_W'(TABLE_SLOTS));
    assign h_idx    = IDX_W'(hword - 1'b1);

    // lowest row that still has a free slot
    always_comb begin
        free_row = '0;
        all_full = 1'b1;
        for (int r = ROWS - 1; r >= 0; r--) begin
            if (!r_row_full[r]) begin
                free_row = ROW_IDX_W'(r);
                all_full = 1'b0;
            end
        end
    end

    assign rd_row = (i_in_item.command == CMD_ALLOCATE) ? free_row
                                                        : ROW_IDX_W'(h_idx >> BIT_W);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command     <= i_in_item.command;
            r_object      <= i_in_item.object_id;
            r_access      <= i_in_item.access_rights;
            r_range_ok    <= range_ok;
            r_full        <= all_full;
            r_row         <= rd_row;
            r_hbit        <= BIT_W'(h_idx);
            r_bm_rd       <= bitmap_mem[rd_row];
            r_bm_rd_valid <= r_row_valid[rd_row];
            r_slot_rd     <= slot_mem[h_idx];
        end
    end

    // --------------------------------------------------------------- execute
    // slots past the end of the table look permanently used
    always_comb begin
        for (int b = 0; b < ROW_W; b++) begin
            pad_mask[b] = ({1'b0, r_row, BIT_W'(b)} >= (ROW_IDX_W+BIT_W+1)'(TABLE_SLOTS));
        end
    end

    assign row_eff = (r_bm_rd_valid ? r_bm_rd : '0) | pad_mask;

    always_comb begin
        free_bit = '0;
        for (int b = ROW_W - 1; b >= 0; b--) begin
            if (!row_eff[b]) begin
                free_bit = BIT_W'(b);
            end
        end
    end

    assign slot_idx = IDX_W'({r_row, free_bit});
    assign hit      = r_range_ok && row_eff[r_hbit];

    always_comb begin
        result             = '0;
        result.status      = ST_INVALID;
        bm_we              = 1'b0;
        slot_we            = 1'b0;
        new_row            = row_eff;
        case (r_command)
            CMD_ALLOCATE: begin
                if (r_full) begin
                    result.status = ST_FULL;
                end else begin
                    result.status     = ST_OK;
                    result.handle_out = HANDLE_OUT_W'({(IDX_W+1)'(slot_idx) + 1'b1, 2'b00});
                    new_row[free_bit] = 1'b1;
                    bm_we             = 1'b1;
                    slot_we           = 1'b1;
                end
            end
            CMD_FREE: begin
                if (hit) begin
                    result.status   = ST_OK;
                    new_row[r_hbit] = 1'b0;
                    bm_we           = 1'b1;
                end
            end
            CMD_LOOKUP: begin
                if (hit) begin
                    result.status       = ST_OK;
                    result.found_object = r_slot_rd[2*WORD_W-1:WORD_W];
                    result.found_access = r_slot_rd[WORD_W-1:0];
                end
            end
            default: result.status = ST_INVALID;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && bm_we) begin
            bitmap_mem[r_row] <= new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && slot_we) begin
            slot_mem[slot_idx] <= {r_object, r_access};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_row_full  <= '0;
        end else if (i_cmd.exec && bm_we) begin
            r_row_valid[r_row] <= 1'b1;
            r_row_full[r_row]  <= &new_row;
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_item <= result;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out_item;

endmodule

>>> design/handle_table_allocator.sv
// ----------------------------------------------------------------------------
// handle_table_allocator
// First-free-slot handle table: allocate, free and look up object handles.
// ----------------------------------------------------------------------------
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+-----------------------
//  command | i_in_valid  | o_in_stall   | i_in_item  (t_in_item)
//  result  | o_out_valid | i_out_stall  | o_out_item (t_out_item)
//
//  Each command first decodes the handle or picks the first non-full bitmap
//  row and reads the bitmap and slot memories, then resolves the slot and
//  writes back. The memory read-modify-write sets the rate.
//  Synchronous reset empties the table at once through per-row valid bits.
//  A result waits in the output register; one more command is taken
//  meanwhile and holds in execute until the result transfers.
// ----------------------------------------------------------------------------
module handle_table_allocator
    import hta_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    hta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd)
    );

    hta_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .i_in_item   (i_in_item),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
